FILE: src/segment_intersection_test_defines.svh
// Assertion macros for the segment intersection test.
// Expects signals named clock and reset in the module that uses them.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segment intersection check failed");

// Consequent must hold in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segment intersection check failed");

`endif

FILE: src/segint_pkg.sv
// Shared types and codes for the segment intersection test.
// No dependencies.
`timescale 1ns / 1ps

package segint_pkg;

   // Orientation of a point triple, from the sign of a cross product.
   typedef logic [1:0] ori_type;

   localparam ori_type ORI_COLLINEAR = 2'd0;
   localparam ori_type ORI_CW        = 2'd1;
   localparam ori_type ORI_CCW       = 2'd2;

endpackage

FILE: src/segint_req_if.sv
// Request channel of the segment intersection test: two segments per beat.
// Valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface segint_req_if #(
   parameter int COORD_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_start_x;
   logic signed [COORD_WIDTH-1:0] first_start_y;
   logic signed [COORD_WIDTH-1:0] first_end_x;
   logic signed [COORD_WIDTH-1:0] first_end_y;
   logic signed [COORD_WIDTH-1:0] second_start_x;
   logic signed [COORD_WIDTH-1:0] second_start_y;
   logic signed [COORD_WIDTH-1:0] second_end_x;
   logic signed [COORD_WIDTH-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

FILE: src/segint_rsp_if.sv
// Response channel of the segment intersection test: one flag per beat.
// Valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface segint_rsp_if ();
   logic valid;
   logic ready;
   logic intersects;

   modport source (
      output valid, intersects,
      input  ready
   );

   modport sink (
      input  valid, intersects,
      output ready
   );
endinterface

FILE: src/segment_intersection_test.sv
// Segment intersection test: request channel req_chan carries two segments
// (p1-q1 and p2-q2), response channel rsp_chan carries the intersects flag.
// Both channels use valid/ready; a beat moves when both are high.
// Pipeline of four register stages:
//   1. endpoint differences and bounding-box compares
//   2. eight signed products, (COORD_WIDTH+1) x (COORD_WIDTH+1) bits each
//   3. cross-product subtraction and orientation codes
//   4. output register holding the flag
// Each request beat passes the stage registers in order. Throughput is one
// pair per cycle when not stalled; the multiplier stage sets the clock.
// Each stage advances whenever it is empty or its successor advances, so
// a stalled receiver fills the pipeline bubble by bubble and then drops
// req_chan.ready; nothing is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// Depends on segint_pkg, segint_req_if, segint_rsp_if and the assertion
// macros in segment_intersection_test_defines.svh.
`timescale 1ns / 1ps
`include "segment_intersection_test_defines.svh"

module segment_intersection_test #(
   parameter int COORD_WIDTH = 16
) (
   input logic          clock,
   input logic          reset,
   segint_req_if.sink   req_chan,
   segint_rsp_if.source rsp_chan
);
   import segint_pkg::*;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int N_ORI   = 4;

   // Point p lies in the axis-aligned box of segment s-e.
   function automatic logic in_box(
      input logic signed [COORD_WIDTH-1:0] sx, sy, px, py, ex, ey
   );
      logic in_x;
      logic in_y;
      in_x = (px >= sx && px <= ex) || (px >= ex && px <= sx);
      in_y = (py >= sy && py <= ey) || (py >= ey && py <= sy);
      return in_x && in_y;
   endfunction

   // Sign-extended difference b - a.
   function automatic logic signed [DIFF_W-1:0] sdiff(
      input logic signed [COORD_WIDTH-1:0] b, a
   );
      return $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
   endfunction

   // Stage control
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic take1, take2, take3, out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign take3    = !v3_ff || out_free;
   assign take2    = !v2_ff || take3;
   assign take1    = !v1_ff || take2;

   assign req_chan.ready = take1;

   // Stage 1: differences for each triple (a, b, c) and box flags
   logic signed [DIFF_W-1:0] abx_in [N_ORI];
   logic signed [DIFF_W-1:0] aby_in [N_ORI];
   logic signed [DIFF_W-1:0] cbx_in [N_ORI];
   logic signed [DIFF_W-1:0] cby_in [N_ORI];
   logic signed [DIFF_W-1:0] abx_ff [N_ORI];
   logic signed [DIFF_W-1:0] aby_ff [N_ORI];
   logic signed [DIFF_W-1:0] cbx_ff [N_ORI];
   logic signed [DIFF_W-1:0] cby_ff [N_ORI];
   logic [N_ORI-1:0]         box_in, box1_ff, box2_ff, box3_ff;

   always_comb begin
      // first segment as base: triples (p1,q1,p2) and (p1,q1,q2)
      abx_in[0] = sdiff(req_chan.first_end_x, req_chan.first_start_x);
      aby_in[0] = sdiff(req_chan.first_end_y, req_chan.first_start_y);
      abx_in[1] = abx_in[0];
      aby_in[1] = aby_in[0];
      cbx_in[0] = sdiff(req_chan.second_start_x, req_chan.first_end_x);
      cby_in[0] = sdiff(req_chan.second_start_y, req_chan.first_end_y);
      cbx_in[1] = sdiff(req_chan.second_end_x, req_chan.first_end_x);
      cby_in[1] = sdiff(req_chan.second_end_y, req_chan.first_end_y);
      // second segment as base: triples (p2,q2,p1) and (p2,q2,q1)
      abx_in[2] = sdiff(req_chan.second_end_x, req_chan.second_start_x);
      aby_in[2] = sdiff(req_chan.second_end_y, req_chan.second_start_y);
      abx_in[3] = abx_in[2];
      aby_in[3] = aby_in[2];
      cbx_in[2] = sdiff(req_chan.first_start_x, req_chan.second_end_x);
      cby_in[2] = sdiff(req_chan.first_start_y, req_chan.second_end_y);
      cbx_in[3] = sdiff(req_chan.first_end_x, req_chan.second_end_x);
      cby_in[3] = sdiff(req_chan.first_end_y, req_chan.second_end_y);

      box_in[0] = in_box(req_chan.first_start_x, req_chan.first_start_y,
                         req_chan.second_start_x, req_chan.second_start_y,
                         req_chan.first_end_x, req_chan.first_end_y);
      box_in[1] = in_box(req_chan.first_start_x, req_chan.first_start_y,
                         req_chan.second_end_x, req_chan.second_end_y,
                         req_chan.first_end_x, req_chan.first_end_y);
      box_in[2] = in_box(req_chan.second_start_x, req_chan.second_start_y,
                         req_chan.first_start_x, req_chan.first_start_y,
                         req_chan.second_end_x, req_chan.second_end_y);
      box_in[3] = in_box(req_chan.second_start_x, req_chan.second_start_y,
                         req_chan.first_end_x, req_chan.first_end_y,
                         req_chan.second_end_x, req_chan.second_end_y);
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         abx_ff  <= abx_in;
         aby_ff  <= aby_in;
         cbx_ff  <= cbx_in;
         cby_ff  <= cby_in;
         box1_ff <= box_in;
      end
   end

   // Stage 2: products of each cross term
   logic signed [PROD_W-1:0] pa_in [N_ORI];
   logic signed [PROD_W-1:0] pb_in [N_ORI];
   logic signed [PROD_W-1:0] pa_ff [N_ORI];
   logic signed [PROD_W-1:0] pb_ff [N_ORI];

   always_comb begin
      for (int i = 0; i < N_ORI; i++) begin
         pa_in[i] = aby_ff[i] * cbx_ff[i];
         pb_in[i] = abx_ff[i] * cby_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (take2) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         box2_ff <= box1_ff;
      end
   end

   // Stage 3: subtract and classify by sign
   logic signed [CROSS_W-1:0] cross_in [N_ORI];
   ori_type                   ori_in   [N_ORI];
   ori_type                   ori_ff   [N_ORI];

   always_comb begin
      for (int i = 0; i < N_ORI; i++) begin
         cross_in[i] = $signed({pa_ff[i][PROD_W-1], pa_ff[i]})
                     - $signed({pb_ff[i][PROD_W-1], pb_ff[i]});
         if (cross_in[i] == '0) begin
            ori_in[i] = ORI_COLLINEAR;
         end else if (cross_in[i][CROSS_W-1]) begin
            ori_in[i] = ORI_CCW;
         end else begin
            ori_in[i] = ORI_CW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take3) begin
         ori_ff  <= ori_in;
         box3_ff <= box2_ff;
      end
   end

   // Stage 4: combine orientations and box flags into the result
   logic crossing;
   logic touching;
   logic intersects_in, intersects_ff;

   always_comb begin
      crossing = (ori_ff[0] != ori_ff[1]) && (ori_ff[2] != ori_ff[3]);
      touching = 1'b0;
      for (int i = 0; i < N_ORI; i++) begin
         touching = touching || ((ori_ff[i] == ORI_COLLINEAR) && box3_ff[i]);
      end
      intersects_in = crossing || touching;
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         intersects_ff <= intersects_in;
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1) begin
            v1_ff <= req_chan.valid;
         end
         if (take2) begin
            v2_ff <= v1_ff;
         end
         if (take3) begin
            v3_ff <= v2_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.intersects = intersects_ff;

   // Pipeline checks
   `SIT_ASSERT_NEXT(a_req_beat_enters, req_chan.valid && req_chan.ready, v1_ff)
   `SIT_ASSERT_SAME(a_full_when_blocked, !req_chan.ready,
      v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_chan.ready)
   `SIT_ASSERT_NEXT(a_stage3_drains, v3_ff && out_free, rsp_valid_ff)
   `SIT_ASSERT_NEXT(a_crossing_hits,
      v3_ff && out_free && (ori_ff[0] != ori_ff[1]) && (ori_ff[2] != ori_ff[3]),
      intersects_ff)

endmodule

FILE: test/testbench.sv
// Testbench for segment_intersection_test: directed segment pairs, then random pairs.
// Each response beat is checked against a table flag or an orientation-based predictor.
// Depends on segint_pkg, segint_req_if, segint_rsp_if and the block itself.
`timescale 1ns / 1ps

module testbench;
   import segint_pkg::*;

   localparam int COORD_W = 16;
   localparam int DIR_ROWS = 24;
   localparam int RANDOM_PAIRS = 1550;
   localparam int DRAIN_EVERY = 400;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      coord_type p1x, p1y, q1x, q1y;
      coord_type p2x, p2y, q2x, q2y;
   } seg_pair_type;

   // How a directed row gets its expected flag.
   typedef enum logic [1:0] {EXP_PREDICT, EXP_HIT, EXP_MISS} exp_kind_type;

   typedef struct {
      seg_pair_type pair;
      exp_kind_type kind;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   segint_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   segint_rsp_if rsp_chan ();

   segment_intersection_test #(.COORD_WIDTH(COORD_W)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic hit_expected_q [$];
   int   mismatch_count = 0;
   int   burst_left = 0;

   // Directed pairs: crossings, misses, collinear and degenerate cases, extremes.
   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{0, 0, 10, 10, 0, 10, 10, 0}, EXP_HIT},
      '{'{0, 0, 10, 0, 0, 5, 10, 5}, EXP_MISS},
      '{'{0, 0, 10, 0, 5, 0, 15, 0}, EXP_HIT},
      '{'{0, 0, 4, 0, 5, 0, 9, 0}, EXP_MISS},
      '{'{0, 0, 4, 0, 4, 0, 9, 0}, EXP_HIT},
      '{'{0, 0, 5, 5, 5, 5, 10, 0}, EXP_HIT},
      '{'{0, 0, 10, 0, 5, 0, 5, 8}, EXP_HIT},
      '{'{3, -10, 3, 10, 3, -2, 3, 2}, EXP_HIT},
      '{'{0, 0, 10, 10, 3, 3, 3, 3}, EXP_HIT},
      '{'{0, 0, 10, 10, 3, 4, 3, 4}, EXP_MISS},
      '{'{7, -7, 7, -7, 7, -7, 7, -7}, EXP_HIT},
      '{'{1, 1, 1, 1, 2, 2, 2, 2}, EXP_MISS},
      '{'{0, 0, 1, 1, 2, 2, 3, 3}, EXP_MISS},
      '{'{0, 0, 1, 1, 0, 10, 10, 0}, EXP_MISS},
      '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, EXP_HIT},
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, EXP_HIT},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, EXP_HIT},
      '{'{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}, EXP_MISS},
      '{'{-32768, 0, 32767, 0, -1, 0, 0, 0}, EXP_HIT},
      '{'{0, -32768, 0, 32767, -32768, 0, 32767, 0}, EXP_HIT},
      '{'{-32768, -32768, 32767, 32766, 32767, 32767, -32768, 32767}, EXP_PREDICT},
      '{'{-32768, 12345, 32767, -321, 100, -32768, -5000, 32767}, EXP_PREDICT},
      '{'{21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846}, EXP_PREDICT},
      '{'{-1, -1, -1, -1, 32767, -32768, -32768, 32767}, EXP_PREDICT}
   };

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard limit on run length.
   initial begin
      #1_500_000;
      $display("Some tests failed");
      $finish;
   end

   // Orientation of triple (a, b, c) from the sign of the exact cross product.
   function automatic ori_type triple_orientation(coord_type ax, coord_type ay, coord_type bx,
                                                  coord_type by, coord_type cx, coord_type cy);
      longint cross_val;
      cross_val = (longint'(by) - longint'(ay)) * (longint'(cx) - longint'(bx))
                - (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(by));
      if (cross_val == 0)
         return ORI_COLLINEAR;
      return (cross_val < 0) ? ORI_CCW : ORI_CW;
   endfunction

   // Point (px, py) lies within the bounding box of segment s-e.
   function automatic logic within_box(coord_type sx, coord_type sy, coord_type px,
                                       coord_type py, coord_type ex, coord_type ey);
      coord_type xmax, xmin, ymax, ymin;
      xmax = (sx > ex) ? sx : ex;
      xmin = (sx < ex) ? sx : ex;
      ymax = (sy > ey) ? sy : ey;
      ymin = (sy < ey) ? sy : ey;
      return (px <= xmax) && (px >= xmin) && (py <= ymax) && (py >= ymin);
   endfunction

   // Expected intersects flag for one segment pair.
   function automatic logic segments_touch(seg_pair_type s);
      ori_type o1, o2, o3, o4;
      o1 = triple_orientation(s.p1x, s.p1y, s.q1x, s.q1y, s.p2x, s.p2y);
      o2 = triple_orientation(s.p1x, s.p1y, s.q1x, s.q1y, s.q2x, s.q2y);
      o3 = triple_orientation(s.p2x, s.p2y, s.q2x, s.q2y, s.p1x, s.p1y);
      o4 = triple_orientation(s.p2x, s.p2y, s.q2x, s.q2y, s.q1x, s.q1y);
      if (o1 != o2 && o3 != o4)
         return 1'b1;
      if (o1 == ORI_COLLINEAR && within_box(s.p1x, s.p1y, s.p2x, s.p2y, s.q1x, s.q1y))
         return 1'b1;
      if (o2 == ORI_COLLINEAR && within_box(s.p1x, s.p1y, s.q2x, s.q2y, s.q1x, s.q1y))
         return 1'b1;
      if (o3 == ORI_COLLINEAR && within_box(s.p2x, s.p2y, s.p1x, s.p1y, s.q2x, s.q2y))
         return 1'b1;
      if (o4 == ORI_COLLINEAR && within_box(s.p2x, s.p2y, s.q1x, s.q1y, s.q2x, s.q2y))
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic int rand_span(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Idle length: mostly short, a few long.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85)
         return rand_span(1, 3);
      return rand_span(6, 30);
   endfunction

   function automatic int edge_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return rand_span(-32768, 32767);
      endcase
   endfunction

   // Random pair, biased toward collinear, touching and degenerate geometry.
   function automatic seg_pair_type random_pair();
      int xs [4];
      int ys [4];
      int bx, by, dx, dy, off_x, off_y, i, j;
      seg_pair_type s;
      case ($urandom_range(0, 9)) inside
         0, 1, 9: begin
            for (i = 0; i < 4; i++) begin
               xs[i] = rand_span(-32768, 32767);
               ys[i] = rand_span(-32768, 32767);
            end
         end
         2, 3, 7: begin
            // small grid somewhere in the plane, shared endpoint now and then
            off_x = rand_span(-32760, 32759);
            off_y = rand_span(-32760, 32759);
            for (i = 0; i < 4; i++) begin
               xs[i] = off_x + rand_span(-8, 8);
               ys[i] = off_y + rand_span(-8, 8);
            end
            if ($urandom_range(0, 1) == 1) begin
               i = rand_span(0, 1);
               j = rand_span(2, 3);
               xs[j] = xs[i];
               ys[j] = ys[i];
            end
         end
         4, 5, 6: begin
            // all four points on one line, a point nudged off it at times
            bx = rand_span(-16000, 16000);
            by = rand_span(-16000, 16000);
            dx = rand_span(-60, 60);
            dy = rand_span(-60, 60);
            for (i = 0; i < 4; i++) begin
               j = rand_span(-200, 200);
               xs[i] = bx + j * dx;
               ys[i] = by + j * dy;
            end
            if ($urandom_range(0, 2) == 0) begin
               xs[1] = xs[0];
               ys[1] = ys[0];
            end
            if ($urandom_range(0, 2) == 0) begin
               xs[3] = xs[2];
               ys[3] = ys[2];
            end
            if ($urandom_range(0, 3) == 0) begin
               i = rand_span(0, 3);
               xs[i] += rand_span(-1, 1);
               ys[i] += rand_span(-1, 1);
            end
         end
         default: begin
            for (i = 0; i < 4; i++) begin
               xs[i] = edge_coord();
               ys[i] = edge_coord();
            end
         end
      endcase
      s.p1x = coord_type'(xs[0]);
      s.p1y = coord_type'(ys[0]);
      s.q1x = coord_type'(xs[1]);
      s.q1y = coord_type'(ys[1]);
      s.p2x = coord_type'(xs[2]);
      s.p2y = coord_type'(ys[2]);
      s.q2x = coord_type'(xs[3]);
      s.q2y = coord_type'(ys[3]);
      return s;
   endfunction

   // Sender gap: zero inside idle-free bursts, otherwise random.
   function automatic int sender_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = rand_span(20, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      return idle_len();
   endfunction

   // Idle for the gap, then hold one request beat until it is accepted.
   task automatic send_pair(seg_pair_type s, logic want_hit);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.first_start_x  <= s.p1x;
      req_chan.first_start_y  <= s.p1y;
      req_chan.first_end_x    <= s.q1x;
      req_chan.first_end_y    <= s.q1y;
      req_chan.second_start_x <= s.p2x;
      req_chan.second_start_y <= s.p2y;
      req_chan.second_end_x   <= s.q2x;
      req_chan.second_end_y   <= s.q2y;
      do
         @(posedge clock);
      while (!req_chan.ready);
      // queue the expected flag at the tail
      hit_expected_q = {hit_expected_q, want_hit};
   endtask

   // Drop valid and wait until every pending response has arrived.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (hit_expected_q.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus: directed table, then random pairs.
   initial begin
      int n;
      logic want_hit;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.first_start_x  <= '0;
      req_chan.first_start_y  <= '0;
      req_chan.first_end_x    <= '0;
      req_chan.first_end_y    <= '0;
      req_chan.second_start_x <= '0;
      req_chan.second_start_y <= '0;
      req_chan.second_end_x   <= '0;
      req_chan.second_end_y   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIR_ROWS; n++) begin
         case (dir_table[n].kind)
            EXP_HIT:  want_hit = 1'b1;
            EXP_MISS: want_hit = 1'b0;
            default:  want_hit = segments_touch(dir_table[n].pair);
         endcase
         send_pair(dir_table[n].pair, want_hit);
      end
      drain_responses();

      for (n = 0; n < RANDOM_PAIRS; n++) begin
         seg_pair_type s;
         s = random_pair();
         send_pair(s, segments_touch(s));
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
            drain_responses();
      end

      // Drain, then let the pipeline settle to catch stray beats.
      drain_responses();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Response side: check each beat, stall ready at random.
   initial begin
      int hold;
      logic rdy;
      logic want_hit;
      hold = 0;
      rdy = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (hit_expected_q.size() == 0) begin
               $display("%0t: response beat with nothing pending, actual intersects=%0b",
                        $time, rsp_chan.intersects);
               mismatch_count++;
            end else begin
               want_hit = hit_expected_q.pop_front();
               if (rsp_chan.intersects !== want_hit) begin
                  $display("%0t: intersects mismatch, expected %0b actual %0b",
                           $time, want_hit, rsp_chan.intersects);
                  mismatch_count++;
               end
            end
         end
         // advance the ready schedule
         if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 99) < 25) begin
            rdy = 1'b0;
            hold = idle_len() - 1;
         end else begin
            rdy = 1'b1;
            hold = ($urandom_range(0, 19) == 0) ? 80 : rand_span(0, 6);
         end
         rsp_chan.ready <= rdy;
      end
   end

endmodule

FILE: sim.f
+incdir+src
src/segint_pkg.sv
src/segint_req_if.sv
src/segint_rsp_if.sv
src/segment_intersection_test.sv
test/testbench.sv
